// ===== rtl/core/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cell balance controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

   localparam int LANE_COUNT       = 4;
   localparam int CELL_COUNT_DFLT  = 4;
   localparam int VOLT_W           = 16;
   localparam int TIME_W           = 32;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 16;

   typedef logic [VOLT_W-1:0]      volt_type;
   typedef logic [TIME_W-1:0]      time_type;
   typedef logic [LANE_COUNT-1:0]  mask_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BALANCE_ENABLE   = 3'd0,
      CSR_BALANCE_IN_RELAX = 3'd1,
      CSR_UPPER_LIMIT      = 3'd2,
      CSR_LOWER_LIMIT      = 3'd3,
      CSR_START_DELTA      = 3'd4,
      CSR_STOP_DELTA       = 3'd5,
      CSR_TICK_PERIOD      = 3'd6
   } csr_index_type;

   localparam volt_type UPPER_LIMIT_RST = 16'd4400;
   localparam volt_type LOWER_LIMIT_RST = 16'd3000;
   localparam volt_type START_DELTA_RST = 16'd40;
   localparam volt_type STOP_DELTA_RST  = 16'd20;
   localparam volt_type TICK_PERIOD_RST = 16'd250;

   // per-lane findings handed to the merge stage
   typedef struct packed {
      logic start;
      logic keep;
      logic old;
   } lane_status_type;

   // merged command set of one transaction
   typedef struct packed {
      mask_type mask;
      logic     active;
      logic     enable;
      logic     disable_all;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/cell_balance_controller.sv =====
// ----------------------------------------------------------------------------
// cell_balance_controller
// Passive cell balancing with start/stop hysteresis and balance-time counters.
//
// One req_ transaction is one measurement tick: four cell voltages, pack max
// and min, charging and relaxed flags. Each tick yields exactly one rsp_
// transaction with the bleed mask, the enable / disable-all commands and the
// four balance-time counters after that tick.
// Results are registered in the output stage. Throughput is one tick per cycle
// while req_stall is low; the per-cell lanes update the mask and counters in
// the accepting cycle, so ticks may follow back to back.
// A two-entry output stage (result register plus skid register) decouples the
// sides: req_stall rises only when both entries hold untaken results, so one
// more tick is taken while a result waits under rsp_stall.
// csr_ writes set the seven settings; they are meant for idle periods only.
// Reset (synchronous) restores the default settings, clears the bleed mask
// and all counters, and empties the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_balance_controller #(
   parameter int CELL_COUNT = cbc_pkg::CELL_COUNT_DFLT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [15:0]                   req_cell_volt_1,
   input  wire  [15:0]                   req_cell_volt_2,
   input  wire  [15:0]                   req_cell_volt_3,
   input  wire  [15:0]                   req_cell_volt_4,
   input  wire  [15:0]                   req_max_cell_volt,
   input  wire  [15:0]                   req_min_cell_volt,
   input  wire                           req_is_charging,
   input  wire                           req_is_relaxed,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [3:0]                    rsp_bleed_mask,
   output logic                          rsp_balancing_active,
   output logic                          rsp_enable_command,
   output logic                          rsp_disable_all_command,
   output logic [31:0]                   rsp_cell_time_1,
   output logic [31:0]                   rsp_cell_time_2,
   output logic [31:0]                   rsp_cell_time_3,
   output logic [31:0]                   rsp_cell_time_4,
   input  wire                           csr_write_enable,
   input  wire  [cbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [cbc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import cbc_pkg::*;

   typedef struct packed {
      cmd_type  cmd;
      time_type t1;
      time_type t2;
      time_type t3;
      time_type t4;
   } result_type;

   logic     bal_enable_ff;
   logic     bal_relax_ff;
   volt_type upper_ff;
   volt_type lower_ff;
   volt_type start_delta_ff;
   volt_type stop_delta_ff;
   volt_type tick_ff;

   volt_type        cell_volt [LANE_COUNT];
   lane_status_type status    [LANE_COUNT];
   time_type        time_next [LANE_COUNT];
   cmd_type         cmd;
   logic            accept;
   logic            allowed;
   logic            spread_ok;
   logic [VOLT_W:0] spread;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   result_type result;
   logic       out_take;

   // ---------------- settings ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bal_enable_ff  <= 1'b0;
         bal_relax_ff   <= 1'b0;
         upper_ff       <= UPPER_LIMIT_RST;
         lower_ff       <= LOWER_LIMIT_RST;
         start_delta_ff <= START_DELTA_RST;
         stop_delta_ff  <= STOP_DELTA_RST;
         tick_ff        <= TICK_PERIOD_RST;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_BALANCE_ENABLE:   bal_enable_ff  <= csr_write_data[0];
            CSR_BALANCE_IN_RELAX: bal_relax_ff   <= csr_write_data[0];
            CSR_UPPER_LIMIT:      upper_ff       <= csr_write_data[VOLT_W-1:0];
            CSR_LOWER_LIMIT:      lower_ff       <= csr_write_data[VOLT_W-1:0];
            CSR_START_DELTA:      start_delta_ff <= csr_write_data[VOLT_W-1:0];
            CSR_STOP_DELTA:       stop_delta_ff  <= csr_write_data[VOLT_W-1:0];
            CSR_TICK_PERIOD:      tick_ff        <= csr_write_data[VOLT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- qualification ----------------
   assign accept = req_valid & ~req_stall;
   assign spread = {1'b0, req_max_cell_volt} - {1'b0, req_min_cell_volt};

   always_comb begin
      allowed   = bal_enable_ff & (req_is_charging | (bal_relax_ff & req_is_relaxed))
                & (req_max_cell_volt < upper_ff) & (req_min_cell_volt >= lower_ff);
      spread_ok = ~spread[VOLT_W] & (spread[VOLT_W-1:0] >= start_delta_ff);
      cell_volt[0] = req_cell_volt_1;
      cell_volt[1] = req_cell_volt_2;
      cell_volt[2] = req_cell_volt_3;
      cell_volt[3] = req_cell_volt_4;
   end

   // ---------------- lanes ----------------
   for (genvar k = 0; k < LANE_COUNT; k++) begin : g_lane
      if (k < CELL_COUNT) begin : g_used
         cbc_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .accept      (accept),
            .allowed     (allowed),
            .spread_ok   (spread_ok),
            .cell_volt   (cell_volt[k]),
            .min_volt    (req_min_cell_volt),
            .start_delta (start_delta_ff),
            .stop_delta  (stop_delta_ff),
            .tick_period (tick_ff),
            .status      (status[k]),
            .time_next   (time_next[k])
         );
      end else begin : g_unused
         assign status[k]    = '0;
         assign time_next[k] = '0;
      end
   end

   cbc_merge u_merge (
      .allowed (allowed),
      .status  (status),
      .cmd     (cmd)
   );

   assign result = '{cmd: cmd, t1: time_next[0], t2: time_next[1],
                     t3: time_next[2], t4: time_next[3]};

   // ---------------- output stage ----------------
   assign out_take  = out_valid_ff & ~rsp_stall;
   assign req_stall = skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_bleed_mask          = out_ff.cmd.mask;
   assign rsp_balancing_active    = out_ff.cmd.active;
   assign rsp_enable_command      = out_ff.cmd.enable;
   assign rsp_disable_all_command = out_ff.cmd.disable_all;
   assign rsp_cell_time_1         = out_ff.t1;
   assign rsp_cell_time_2         = out_ff.t2;
   assign rsp_cell_time_3         = out_ff.t3;
   assign rsp_cell_time_4         = out_ff.t4;

   // ---------------- assertions ----------------
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without result entry");

   a_disable_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_disable_all_command |->
         rsp_bleed_mask == '0 && !rsp_enable_command)
      else $error("disable-all issued with cells still bleeding");

   a_active_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_balancing_active == (rsp_bleed_mask != '0))
      else $error("balancing_active disagrees with bleed mask");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff && !skid_valid_ff)
      else $error("output stage not empty after reset");

endmodule

`default_nettype wire

// ===== rtl/core/cbc_lane.sv =====
// ----------------------------------------------------------------------------
// cbc_lane
// One cell: start/stop hysteresis compare, bleed bit and balance-time counter.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_lane (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       accept,
   input  wire                       allowed,
   input  wire                       spread_ok,
   input  wire  cbc_pkg::volt_type   cell_volt,
   input  wire  cbc_pkg::volt_type   min_volt,
   input  wire  cbc_pkg::volt_type   start_delta,
   input  wire  cbc_pkg::volt_type   stop_delta,
   input  wire  cbc_pkg::volt_type   tick_period,
   output cbc_pkg::lane_status_type  status,
   output cbc_pkg::time_type         time_next
);
   import cbc_pkg::*;

   logic                active_ff;
   logic                active_in;
   time_type            time_ff;
   logic [VOLT_W:0]     excess;
   logic                drop;

   // signed excess over pack minimum; bit VOLT_W is the sign
   assign excess = {1'b0, cell_volt} - {1'b0, min_volt};
   assign drop   = excess[VOLT_W] | (excess[VOLT_W-1:0] < stop_delta);

   always_comb begin
      status.old   = active_ff;
      status.keep  = active_ff & ~drop;
      status.start = spread_ok & ~excess[VOLT_W] & (excess[VOLT_W-1:0] >= start_delta);
      active_in    = allowed & (status.keep | status.start);
      time_next    = (allowed & active_ff)
                   ? time_ff + {{(TIME_W-VOLT_W){1'b0}}, tick_period}
                   : time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         time_ff   <= '0;
      end else if (accept) begin
         active_ff <= active_in;
         time_ff   <= time_next;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cbc_merge.sv =====
// ----------------------------------------------------------------------------
// cbc_merge
// Combines the lane findings into the bleed mask and switch commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_merge (
   input  wire                       allowed,
   input  cbc_pkg::lane_status_type  status [cbc_pkg::LANE_COUNT],
   output cbc_pkg::cmd_type          cmd
);
   import cbc_pkg::*;

   mask_type start_vec;
   mask_type keep_vec;
   mask_type old_vec;

   always_comb begin
      for (int k = 0; k < LANE_COUNT; k++) begin
         start_vec[k] = status[k].start;
         keep_vec[k]  = status[k].keep;
         old_vec[k]   = status[k].old;
      end
      cmd.mask        = allowed ? (keep_vec | start_vec) : '0;
      cmd.active      = |cmd.mask;
      cmd.enable      = |cmd.mask;
      cmd.disable_all = allowed & (|old_vec) & ~(|keep_vec) & ~(|start_vec);
   end

endmodule

`default_nettype wire

// ===== tb/sv/cbc_balance_checker.sv =====
// ----------------------------------------------------------------------------
// cbc_balance_checker
// Watches the req_, rsp_ and csr_ ports of the cell balance controller,
// keeps its own copy of the settings, bleed mask and balance-time counters,
// predicts the result of every accepted tick and compares each accepted
// response against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cbc_balance_checker #(
   parameter int CELL_COUNT = cbc_pkg::CELL_COUNT_DFLT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_stall,
   input  wire  [15:0]           req_cell_volt_1,
   input  wire  [15:0]           req_cell_volt_2,
   input  wire  [15:0]           req_cell_volt_3,
   input  wire  [15:0]           req_cell_volt_4,
   input  wire  [15:0]           req_max_cell_volt,
   input  wire  [15:0]           req_min_cell_volt,
   input  wire                   req_is_charging,
   input  wire                   req_is_relaxed,
   input  wire                   rsp_valid,
   input  wire                   rsp_stall,
   input  wire  [3:0]            rsp_bleed_mask,
   input  wire                   rsp_balancing_active,
   input  wire                   rsp_enable_command,
   input  wire                   rsp_disable_all_command,
   input  wire  [31:0]           rsp_cell_time_1,
   input  wire  [31:0]           rsp_cell_time_2,
   input  wire  [31:0]           rsp_cell_time_3,
   input  wire  [31:0]           rsp_cell_time_4,
   input  wire                   csr_write_enable,
   input  wire  [cbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [cbc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cbc_pkg::*;

   typedef struct packed {
      volt_type [LANE_COUNT-1:0] volt;
      volt_type                  vmax;
      volt_type                  vmin;
      logic                      charging;
      logic                      relaxed;
   } tick_type;

   typedef struct packed {
      mask_type                  mask;
      logic                      active;
      logic                      enable;
      logic                      disable_all;
      time_type [LANE_COUNT-1:0] cell_time;
   } outcome_type;

   logic        bal_enable;
   logic        bal_in_relax;
   volt_type    upper_lim;
   volt_type    lower_lim;
   volt_type    start_dlt;
   volt_type    stop_dlt;
   volt_type    tick_ms;

   mask_type    bleeding;
   time_type    bleed_time [LANE_COUNT];
   outcome_type pending_outcomes [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic outcome_type balance_tick(tick_type t);
      outcome_type o;
      mask_type    starts;
      int          spread;
      o      = '0;
      starts = '0;
      spread = int'(t.vmax) - int'(t.vmin);
      if (bal_enable && (t.charging || (bal_in_relax && t.relaxed)) &&
          t.vmax < upper_lim && t.vmin >= lower_lim) begin
         if (spread >= int'(start_dlt)) begin
            for (int k = 0; k < LANE_COUNT; k++)
               if (k < CELL_COUNT && int'(t.volt[k]) - int'(t.vmin) >= int'(start_dlt))
                  starts[k] = 1'b1;
         end
         if (bleeding != '0) begin
            for (int k = 0; k < LANE_COUNT; k++) begin
               if (k < CELL_COUNT && bleeding[k]) begin
                  bleed_time[k] += time_type'(tick_ms);
                  if (int'(t.volt[k]) - int'(t.vmin) < int'(stop_dlt))
                     bleeding[k] = 1'b0;
               end
            end
            o.disable_all = (bleeding == '0) && (starts == '0);
         end
         // a cell dropped by crossed thresholds may restart in the same tick
         bleeding = bleeding | starts;
         o.enable = (bleeding != '0);
      end else begin
         bleeding = '0;
      end
      o.mask   = bleeding;
      o.active = (bleeding != '0);
      for (int k = 0; k < LANE_COUNT; k++)
         o.cell_time[k] = bleed_time[k];
      return o;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      tick_type    t;
      outcome_type want;
      if (reset) begin
         bal_enable   = 1'b0;
         bal_in_relax = 1'b0;
         upper_lim    = UPPER_LIMIT_RST;
         lower_lim    = LOWER_LIMIT_RST;
         start_dlt    = START_DELTA_RST;
         stop_dlt     = STOP_DELTA_RST;
         tick_ms      = TICK_PERIOD_RST;
         bleeding     = '0;
         for (int k = 0; k < LANE_COUNT; k++)
            bleed_time[k] = '0;
         pending_outcomes.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BALANCE_ENABLE:   bal_enable   = csr_write_data[0];
               CSR_BALANCE_IN_RELAX: bal_in_relax = csr_write_data[0];
               CSR_UPPER_LIMIT:      upper_lim    = csr_write_data;
               CSR_LOWER_LIMIT:      lower_lim    = csr_write_data;
               CSR_START_DELTA:      start_dlt    = csr_write_data;
               CSR_STOP_DELTA:       stop_dlt     = csr_write_data;
               CSR_TICK_PERIOD:      tick_ms      = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            t.volt[0]  = req_cell_volt_1;
            t.volt[1]  = req_cell_volt_2;
            t.volt[2]  = req_cell_volt_3;
            t.volt[3]  = req_cell_volt_4;
            t.vmax     = req_max_cell_volt;
            t.vmin     = req_min_cell_volt;
            t.charging = req_is_charging;
            t.relaxed  = req_is_relaxed;
            pending_outcomes.push_back(balance_tick(t));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $error("rsp transaction with no tick outstanding");
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("bleed_mask", want.mask, rsp_bleed_mask);
               check_field("balancing_active", want.active, rsp_balancing_active);
               check_field("enable_command", want.enable, rsp_enable_command);
               check_field("disable_all_command", want.disable_all,
                           rsp_disable_all_command);
               check_field("cell_time_1", want.cell_time[0], rsp_cell_time_1);
               check_field("cell_time_2", want.cell_time[1], rsp_cell_time_2);
               check_field("cell_time_3", want.cell_time[2], rsp_cell_time_3);
               check_field("cell_time_4", want.cell_time[3], rsp_cell_time_4);
            end
         end
      end
      pending_count = pending_outcomes.size();
   end

endmodule

// ===== tb/sv/tb_cell_balance_controller.sv =====
// ----------------------------------------------------------------------------
// tb_cell_balance_controller
// Drives measurement ticks and register settings into the cell balance
// controller under varying sender gaps and receiver stalls; the checker
// beside the block predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_cell_balance_controller;
   timeunit 1ns;
   timeprecision 1ps;
   import cbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [15:0]            req_cell_volt_1;
   logic [15:0]            req_cell_volt_2;
   logic [15:0]            req_cell_volt_3;
   logic [15:0]            req_cell_volt_4;
   logic [15:0]            req_max_cell_volt;
   logic [15:0]            req_min_cell_volt;
   logic                   req_is_charging;
   logic                   req_is_relaxed;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [3:0]             rsp_bleed_mask;
   logic                   rsp_balancing_active;
   logic                   rsp_enable_command;
   logic                   rsp_disable_all_command;
   logic [31:0]            rsp_cell_time_1;
   logic [31:0]            rsp_cell_time_2;
   logic [31:0]            rsp_cell_time_3;
   logic [31:0]            rsp_cell_time_4;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     fail_count;
   int                     pending_count;

   int gap_pct;
   int stall_pct;
   int idle_mode;
   int quiet_cycles;
   int ticks_sent;
   int settings_used;
   int cur_upper;
   int cur_lower;
   int cur_start;
   int cur_stop;

   cell_balance_controller u_dut (.*);

   cbc_balance_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 64; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 64; end
         default: begin gap_pct = 20; stall_pct = 20; end
      endcase
   endtask

   task automatic send_tick(volt_type c1, volt_type c2, volt_type c3, volt_type c4,
                            volt_type vmax, volt_type vmin, logic chg, logic rlx);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_cell_volt_1   <= c1;
      req_cell_volt_2   <= c2;
      req_cell_volt_3   <= c3;
      req_cell_volt_4   <= c4;
      req_max_cell_volt <= vmax;
      req_min_cell_volt <= vmin;
      req_is_charging   <= chg;
      req_is_relaxed    <= rlx;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   // hold the sender off until every outstanding tick has been answered
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic apply_settings(logic en, logic rlx, volt_type upper, volt_type lower,
                                 volt_type start, volt_type stop, volt_type period);
      drain();
      repeat (3) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BALANCE_ENABLE;
      csr_write_data   <= {15'd0, en};
      @(negedge clock);
      csr_index        <= CSR_BALANCE_IN_RELAX;
      csr_write_data   <= {15'd0, rlx};
      @(negedge clock);
      csr_index        <= CSR_UPPER_LIMIT;
      csr_write_data   <= upper;
      @(negedge clock);
      csr_index        <= CSR_LOWER_LIMIT;
      csr_write_data   <= lower;
      @(negedge clock);
      csr_index        <= CSR_START_DELTA;
      csr_write_data   <= start;
      @(negedge clock);
      csr_index        <= CSR_STOP_DELTA;
      csr_write_data   <= stop;
      @(negedge clock);
      csr_index        <= CSR_TICK_PERIOD;
      csr_write_data   <= period;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      cur_upper = int'(upper);
      cur_lower = int'(lower);
      cur_start = int'(start);
      cur_stop  = int'(stop);
      settings_used++;
   endtask

   // mostly plausible packs inside the voltage window, some pure noise
   task automatic send_random_tick();
      int c [4];
      int base;
      int spread;
      int vmax;
      int vmin;
      int roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         send_tick(volt_type'($urandom()), volt_type'($urandom()),
                   volt_type'($urandom()), volt_type'($urandom()),
                   volt_type'($urandom()), volt_type'($urandom()),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
         if (cur_upper > cur_lower)
            base = $urandom_range(cur_upper - 1, cur_lower);
         else
            base = $urandom_range(65535, 0);
         spread = 2 * ((cur_start > cur_stop) ? cur_start : cur_stop) + 8;
         if (spread > 2000)
            spread = 2000;
         for (int k = 0; k < 4; k++) begin
            c[k] = base + $urandom_range(spread, 0);
            if (c[k] > 65535)
               c[k] = 65535;
         end
         c[$urandom_range(3, 0)] = base;
         vmax = c[0];
         vmin = c[0];
         for (int k = 1; k < 4; k++) begin
            if (c[k] > vmax) vmax = c[k];
            if (c[k] < vmin) vmin = c[k];
         end
         // inconsistent extremes: cells below the minimum, max below min
         if (roll < 22) begin
            if ($urandom_range(1)) begin
               vmin = vmin + $urandom_range(spread, 0);
               if (vmin > 65535)
                  vmin = 65535;
            end else begin
               vmax = $urandom_range(vmin, 0);
            end
         end
         send_tick(volt_type'(c[0]), volt_type'(c[1]), volt_type'(c[2]), volt_type'(c[3]),
                   volt_type'(vmax), volt_type'(vmin),
                   ($urandom_range(99) < 80), 1'($urandom_range(1)));
      end
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            set_idling(idle_mode);
            idle_mode++;
         end
         if ($urandom_range(59) == 0)
            drain();
         send_random_tick();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_cell_volt_1   = '0;
      req_cell_volt_2   = '0;
      req_cell_volt_3   = '0;
      req_cell_volt_4   = '0;
      req_max_cell_volt = '0;
      req_min_cell_volt = '0;
      req_is_charging   = 1'b0;
      req_is_relaxed    = 1'b0;
      rsp_stall         = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_BALANCE_ENABLE;
      csr_write_data    = '0;
      gap_pct           = 0;
      stall_pct         = 0;
      idle_mode         = 0;
      quiet_cycles      = 0;
      ticks_sent        = 0;
      settings_used     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default limits with balancing and relax balancing on
      apply_settings(1'b1, 1'b1, 16'd4400, 16'd3000, 16'd40, 16'd20, 16'd250);
      send_tick(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
      send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      send_tick(16'd3000, 16'd3000, 16'd3000, 16'd3000, 16'd3000, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3050, 16'd3000, 16'd3000, 16'd3050, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3030, 16'd3000, 16'd3000, 16'd3030, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3020, 16'd3000, 16'd3000, 16'd3020, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3019, 16'd3000, 16'd3000, 16'd3019, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3040, 16'd3040, 16'd3039, 16'd3040, 16'd3000, 1'b0, 1'b1);
      send_tick(16'd3000, 16'd3100, 16'd3100, 16'd3000, 16'd3100, 16'd3000, 1'b0, 1'b0);
      send_tick(16'd3000, 16'd3100, 16'd3100, 16'd3000, 16'd3100, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd2900, 16'd3100, 16'd3000, 16'd3100, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3200, 16'd3300, 16'd3000, 16'd3000, 16'd3000, 16'd3100, 1'b1, 1'b0);
      send_tick(16'd3100, 16'd3100, 16'd3100, 16'd3100, 16'd3100, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3060, 16'd3000, 16'd3000, 16'd4399, 16'd3000, 1'b1, 1'b1);
      send_tick(16'd3000, 16'd3060, 16'd3000, 16'd3000, 16'd4400, 16'd3000, 1'b1, 1'b1);
      send_tick(16'd2999, 16'd3060, 16'd2999, 16'd2999, 16'd3060, 16'd2999, 1'b1, 1'b1);
      send_tick(16'd3000, 16'd3050, 16'd3000, 16'd3000, 16'd3039, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3050, 16'd3000, 16'd3000, 16'd3040, 16'd3000, 1'b1, 1'b0);
      run_random(60);

      // crossed thresholds: stop above start
      apply_settings(1'b1, 1'b0, 16'd4200, 16'd2500, 16'd10, 16'd60, 16'd1000);
      send_tick(16'd3000, 16'd3030, 16'd3000, 16'd3000, 16'd3030, 16'd3000, 1'b1, 1'b0);
      send_tick(16'd3000, 16'd3030, 16'd3000, 16'd3000, 16'd3030, 16'd3000, 1'b1, 1'b0);
      run_random(100);

      // widest window, zero deltas, largest period
      apply_settings(1'b1, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      run_random(100);

      // window that can never open
      apply_settings(1'b1, 1'b1, 16'd0, 16'hFFFF, 16'd40, 16'd20, 16'd250);
      run_random(40);

      // master enable off
      apply_settings(1'b0, 1'b1, 16'd4400, 16'd3000, 16'd40, 16'd20, 16'd250);
      run_random(40);

      // largest deltas, smallest nonzero period
      apply_settings(1'b1, 1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1);
      run_random(50);

      // zero period while bleeding
      apply_settings(1'b1, 1'b1, 16'd4400, 16'd3000, 16'd40, 16'd20, 16'd0);
      run_random(40);

      for (int p = 0; p < 4; p++) begin
         int lo;
         int hi;
         lo = $urandom_range(4000, 0);
         hi = lo + $urandom_range(1500, 1);
         apply_settings(($urandom_range(99) < 85), 1'($urandom_range(1)),
                        volt_type'(hi), volt_type'(lo),
                        volt_type'($urandom_range(120, 0)),
                        volt_type'($urandom_range(120, 0)),
                        volt_type'($urandom()));
         run_random(85);
      end

      drain();
      repeat (4) @(negedge clock);
      $display("Covered %0d ticks over %0d register settings: window limits, hysteresis,",
               ticks_sent, settings_used);
      $display("crossed thresholds, bad min/max, with back-to-back, gapped and stalled traffic.");
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cbc_pkg.sv
rtl/core/cbc_lane.sv
rtl/core/cbc_merge.sv
rtl/core/cell_balance_controller.sv
tb/sv/cbc_balance_checker.sv
tb/sv/tb_cell_balance_controller.sv
